>>> design/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// shared types and constants of the depth pixel converter
// ----------------------------------------------------------------------------
package dpc_pkg;

   localparam int DEPTH_W = 16;
   localparam int COL_W   = 10;
   localparam int ROW_W   = 9;
   localparam int VALUE_W = 24;
   localparam int WORLD_W = 32;
   localparam int DIV_W   = 33;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [2:0] {
      MODE_NORMALIZED = 3'd0,
      MODE_DISP_8BIT  = 3'd1,
      MODE_DISP_FIXED = 3'd2,
      MODE_POINTCLOUD = 3'd3,
      MODE_VALID_MAP  = 3'd4,
      MODE_RAW        = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE        = 3'd0,
      CSR_SCALE       = 3'd1,
      CSR_DISP_NUM    = 3'd2,
      CSR_INV_FOCAL_X = 3'd3,
      CSR_INV_FOCAL_Y = 3'd4,
      CSR_CENTER_X    = 3'd5,
      CSR_CENTER_Y    = 3'd6,
      CSR_INVALID     = 3'd7
   } csr_index_type;

   localparam logic [2:0]  MODE_RESET    = 3'd5;
   localparam logic [15:0] SCALE_RESET   = 16'd8160;
   localparam logic [23:0] DISP_RESET    = 24'd43125;
   localparam logic [23:0] IFX_RESET     = 24'd28234;
   localparam logic [23:0] IFY_RESET     = 24'd28386;
   localparam logic [17:0] CX_RESET      = 18'd81743;
   localparam logic [17:0] CY_RESET      = 18'd62141;
   localparam logic [15:0] INVALID_RESET = 16'd0;

   typedef struct packed {
      logic                 valid;
      logic [DEPTH_W-1:0]   depth;
      logic                 pixel_valid;
   } side_type;

endpackage

>>> design/dpc_divider.sv
// ----------------------------------------------------------------------------
// dpc_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module dpc_divider (
   input  logic                         clock,
   input  logic                         en,
   input  logic [dpc_pkg::DIV_W-1:0]    dividend,
   input  logic [dpc_pkg::DEPTH_W-1:0]  divisor,
   output logic [dpc_pkg::DIV_W-1:0]    quotient
);

   localparam int NW = dpc_pkg::DIV_W;
   localparam int DW = dpc_pkg::DEPTH_W;

   logic [NW-1:0] num_ff [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] den_ff [NW];

   genvar i;
   generate
      for (i = 0; i < NW; i++) begin : g_stage
         logic [NW-1:0] n_src;
         logic [DW-1:0] r_src;
         logic [DW-1:0] d_src;
         logic [DW:0]   trial;
         logic [DW:0]   diff;
         logic          ge;
         logic [NW-1:0] num_in;
         logic [DW-1:0] rem_in;

         if (i == 0) begin : g_first
            assign n_src = dividend;
            assign r_src = '0;
            assign d_src = divisor;
         end else begin : g_next
            assign n_src = num_ff[i-1];
            assign r_src = rem_ff[i-1];
            assign d_src = den_ff[i-1];
         end

         always_comb begin
            trial  = {r_src, n_src[NW-1]};
            diff   = trial - {1'b0, d_src};
            ge     = trial >= {1'b0, d_src};
            rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
            num_in = {n_src[NW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[i] <= num_in;
               rem_ff[i] <= rem_in;
               den_ff[i] <= d_src;
            end
         end
      end
   endgenerate

   assign quotient = num_ff[NW-1];

endmodule

>>> design/dpc_projector.sv
// ----------------------------------------------------------------------------
// dpc_projector
// five-stage projection of a pixel to world x and y
// ----------------------------------------------------------------------------
module dpc_projector #(
   parameter int FRAME_COLS = 640,
   parameter int FRAME_ROWS = 480
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [dpc_pkg::COL_W-1:0]    column,
   input  logic [dpc_pkg::ROW_W-1:0]    row,
   input  logic [dpc_pkg::DEPTH_W-1:0]  depth,
   input  logic [17:0]                  center_x,
   input  logic [17:0]                  center_y,
   input  logic [23:0]                  inv_focal_x,
   input  logic [23:0]                  inv_focal_y,
   output logic [dpc_pkg::WORLD_W-1:0]  world_x,
   output logic [dpc_pkg::WORLD_W-1:0]  world_y
);

   localparam int COL_MAX = (1 << dpc_pkg::COL_W) - 1;
   localparam int ROW_MAX = (1 << dpc_pkg::ROW_W) - 1;
   localparam int COL_LIM = (FRAME_COLS - 1 > COL_MAX) ? COL_MAX : FRAME_COLS - 1;
   localparam int ROW_LIM = (FRAME_ROWS - 1 > ROW_MAX) ? ROW_MAX : FRAME_ROWS - 1;

   logic [dpc_pkg::COL_W-1:0] col_c;
   logic [dpc_pkg::ROW_W-1:0] row_c;
   logic [17:0]  coord [2];
   logic [17:0]  center [2];
   logic [23:0]  inv [2];
   logic [18:0]  diff [2];

   logic [1:0]   neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [17:0]  mag1_ff [2];
   logic [15:0]  depth1_ff;
   logic [33:0]  md2_ff [2];
   logic [40:0]  hi3_ff [2];
   logic [40:0]  lo3_ff [2];
   logic [34:0]  rnd4_ff [2];
   logic [31:0]  world5_ff [2];

   logic [58:0]  sum [2];
   logic [31:0]  sat [2];

   always_comb begin
      col_c = (column > COL_LIM[dpc_pkg::COL_W-1:0]) ? COL_LIM[dpc_pkg::COL_W-1:0] : column;
      row_c = (row > ROW_LIM[dpc_pkg::ROW_W-1:0]) ? ROW_LIM[dpc_pkg::ROW_W-1:0] : row;
      coord[0]  = {col_c, 8'd0};
      coord[1]  = {1'b0, row_c, 8'd0};
      center[0] = center_x;
      center[1] = center_y;
      inv[0]    = inv_focal_x;
      inv[1]    = inv_focal_y;
      for (int a = 0; a < 2; a++) begin
         diff[a] = {1'b0, coord[a]} - {1'b0, center[a]};
         sum[a]  = {1'b0, hi3_ff[a], 17'd0} + {18'd0, lo3_ff[a]} + 59'h800000;
         if (neg4_ff[a]) begin
            sat[a] = (rnd4_ff[a] > 35'h080000000) ? 32'h80000000
                                                  : 32'd0 - rnd4_ff[a][31:0];
         end else begin
            sat[a] = (rnd4_ff[a] > 35'h07FFFFFFF) ? 32'h7FFFFFFF : rnd4_ff[a][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         depth1_ff <= depth;
         neg2_ff   <= neg1_ff;
         neg3_ff   <= neg2_ff;
         neg4_ff   <= neg3_ff;
         for (int a = 0; a < 2; a++) begin
            neg1_ff[a]   <= diff[a][18];
            mag1_ff[a]   <= diff[a][18] ? 18'(-diff[a]) : diff[a][17:0];
            md2_ff[a]    <= 34'(mag1_ff[a] * depth1_ff);
            hi3_ff[a]    <= 41'(md2_ff[a][33:17] * inv[a]);
            lo3_ff[a]    <= 41'(md2_ff[a][16:0] * inv[a]);
            rnd4_ff[a]   <= sum[a][58:24];
            world5_ff[a] <= sat[a];
         end
      end
   end

   assign world_x = world5_ff[0];
   assign world_y = world5_ff[1];

endmodule

>>> design/depth_pixel_converter_top.sv
// ----------------------------------------------------------------------------
// depth_pixel_converter_top
// converts one depth pixel a cycle, unless stalled, by the configured mode
// ----------------------------------------------------------------------------
// req channel carries depth, column and row; rsp channel carries pixel_value,
// world_x, world_y and pixel_valid, one rsp transaction per req transaction.
// both channels use valid and stall; a transaction happens when valid is high
// and stall is low. csr port writes register csr_index with csr_data on any
// cycle with csr_write high; the user must use it only while the block is
// empty, which the block does not enforce. from req transaction to rsp valid
// a pixel passes an input stage, the 33-stage divider (one quotient bit per
// stage) and the output register; the projection runs in parallel and is
// delayed to match. throughput is one pixel per cycle while rsp does not
// stall. a stall on rsp with a result waiting freezes the whole pipeline and
// raises req_stall in the same cycle; nothing is lost or repeated. reset
// empties the pipeline and loads the register defaults (raw mode).
// ----------------------------------------------------------------------------
module depth_pixel_converter_top #(
   parameter int FRAME_COLS = 640,
   parameter int FRAME_ROWS = 480
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dpc_pkg::DEPTH_W-1:0]     req_depth,
   input  logic [dpc_pkg::COL_W-1:0]       req_column,
   input  logic [dpc_pkg::ROW_W-1:0]       req_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dpc_pkg::VALUE_W-1:0]     rsp_pixel_value,
   output logic signed [dpc_pkg::WORLD_W-1:0] rsp_world_x,
   output logic signed [dpc_pkg::WORLD_W-1:0] rsp_world_y,
   output logic                            rsp_pixel_valid,
   input  logic                            csr_write,
   input  logic [dpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpc_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int DIV_LAT  = dpc_pkg::DIV_W;
   localparam int PROJ_LAT = 5;
   localparam int PAD_LAT  = DIV_LAT - PROJ_LAT;

   logic [2:0]  mode_ff;
   logic [15:0] scale_ff;
   logic [23:0] disp_num_ff;
   logic [23:0] ifx_ff, ify_ff;
   logic [17:0] cx_ff, cy_ff;
   logic [15:0] invalid_ff;

   logic        adv;
   logic        in_valid_ff;
   logic [15:0] in_depth_ff;
   logic [9:0]  in_col_ff;
   logic [8:0]  in_row_ff;
   logic        in_pv_ff;
   logic [dpc_pkg::DIV_W-1:0] in_dividend_ff;
   logic [dpc_pkg::DIV_W-1:0] dividend_in;

   dpc_pkg::side_type side_ff [DIV_LAT];
   dpc_pkg::side_type side_src;
   logic [31:0] pad_x_ff [PAD_LAT];
   logic [31:0] pad_y_ff [PAD_LAT];

   logic [dpc_pkg::DIV_W-1:0] quotient;
   logic [31:0] proj_x, proj_y;

   logic        out_valid_ff;
   logic [23:0] out_value_ff;
   logic [31:0] out_x_ff, out_y_ff;
   logic        out_pv_ff;
   logic [23:0] value_in;
   logic [31:0] x_in, y_in;
   logic [31:0] norm_prod;
   dpc_pkg::side_type last;

   assign adv       = !out_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= dpc_pkg::MODE_RESET;
         scale_ff    <= dpc_pkg::SCALE_RESET;
         disp_num_ff <= dpc_pkg::DISP_RESET;
         ifx_ff      <= dpc_pkg::IFX_RESET;
         ify_ff      <= dpc_pkg::IFY_RESET;
         cx_ff       <= dpc_pkg::CX_RESET;
         cy_ff       <= dpc_pkg::CY_RESET;
         invalid_ff  <= dpc_pkg::INVALID_RESET;
      end else if (csr_write) begin
         case (dpc_pkg::csr_index_type'(csr_index))
            dpc_pkg::CSR_MODE:        mode_ff     <= csr_data[2:0];
            dpc_pkg::CSR_SCALE:       scale_ff    <= csr_data[15:0];
            dpc_pkg::CSR_DISP_NUM:    disp_num_ff <= csr_data;
            dpc_pkg::CSR_INV_FOCAL_X: ifx_ff      <= csr_data;
            dpc_pkg::CSR_INV_FOCAL_Y: ify_ff      <= csr_data;
            dpc_pkg::CSR_CENTER_X:    cx_ff       <= csr_data[17:0];
            dpc_pkg::CSR_CENTER_Y:    cy_ff       <= csr_data[17:0];
            dpc_pkg::CSR_INVALID:     invalid_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // rounded disparity dividend
   always_comb begin
      if (mode_ff == dpc_pkg::MODE_DISP_FIXED) begin
         dividend_in = {1'b0, disp_num_ff, 8'd0} + {18'd0, req_depth[15:1]};
      end else begin
         dividend_in = {9'd0, disp_num_ff} + {18'd0, req_depth[15:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_depth_ff    <= req_depth;
         in_col_ff      <= req_column;
         in_row_ff      <= req_row;
         in_pv_ff       <= req_depth != invalid_ff;
         in_dividend_ff <= dividend_in;
      end
   end

   dpc_divider u_divider (
      .clock    (clock),
      .en       (adv),
      .dividend (in_dividend_ff),
      .divisor  (in_depth_ff),
      .quotient (quotient)
   );

   dpc_projector #(
      .FRAME_COLS (FRAME_COLS),
      .FRAME_ROWS (FRAME_ROWS)
   ) u_projector (
      .clock       (clock),
      .en          (adv),
      .column      (in_col_ff),
      .row         (in_row_ff),
      .depth       (in_depth_ff),
      .center_x    (cx_ff),
      .center_y    (cy_ff),
      .inv_focal_x (ifx_ff),
      .inv_focal_y (ify_ff),
      .world_x     (proj_x),
      .world_y     (proj_y)
   );

   // sideband and projection alignment with the divider
   assign side_src = '{valid: in_valid_ff, depth: in_depth_ff, pixel_valid: in_pv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         side_ff[0] <= side_src;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pad_x_ff[0] <= proj_x;
         pad_y_ff[0] <= proj_y;
         for (int k = 1; k < PAD_LAT; k++) begin
            pad_x_ff[k] <= pad_x_ff[k-1];
            pad_y_ff[k] <= pad_y_ff[k-1];
         end
      end
   end

   // mode selection
   always_comb begin
      last      = side_ff[DIV_LAT-1];
      norm_prod = {16'd0, last.depth} * {16'd0, scale_ff};
      value_in  = '0;
      x_in      = '0;
      y_in      = '0;
      case (dpc_pkg::mode_type'(mode_ff))
         dpc_pkg::MODE_NORMALIZED: begin
            value_in = (norm_prod[31:24] != 8'd0 || norm_prod[23:15] >= 9'd511)
                       ? 24'd255 : 24'((norm_prod + 32'h8000) >> 16);
         end
         dpc_pkg::MODE_DISP_8BIT: begin
            if (!last.pixel_valid) begin
               value_in = (invalid_ff > 16'd255) ? 24'd255 : {8'd0, invalid_ff};
            end else begin
               value_in = (quotient > 33'd255) ? 24'd255 : quotient[23:0];
            end
         end
         dpc_pkg::MODE_DISP_FIXED: begin
            if (!last.pixel_valid) begin
               value_in = {invalid_ff, 8'd0};
            end else begin
               value_in = (quotient[dpc_pkg::DIV_W-1:24] != '0) ? 24'hFFFFFF
                                                               : quotient[23:0];
            end
         end
         dpc_pkg::MODE_POINTCLOUD: begin
            if (last.pixel_valid) begin
               value_in = {last.depth, 8'd0};
               x_in     = pad_x_ff[PAD_LAT-1];
               y_in     = pad_y_ff[PAD_LAT-1];
            end
         end
         dpc_pkg::MODE_VALID_MAP: begin
            value_in = last.pixel_valid ? 24'd255 : 24'd0;
         end
         default: begin
            value_in = {8'd0, last.depth};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_value_ff <= value_in;
         out_x_ff     <= x_in;
         out_y_ff     <= y_in;
         out_pv_ff    <= last.pixel_valid;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_value = out_value_ff;
   assign rsp_world_x     = out_x_ff;
   assign rsp_world_y     = out_y_ff;
   assign rsp_pixel_valid = out_pv_ff;

   a_invalid_no_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |-> rsp_world_x == 0 && rsp_world_y == 0)
      else $error("invalid pixel with nonzero coordinates");

   a_stall_freezes_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result is stalled");

   a_accept_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted transaction lost at input stage");

endmodule

>>> verif/depth_pixel_converter_top_tb.sv
// ----------------------------------------------------------------------------
// depth_pixel_converter_top_tb
// checks every converted pixel against a predicted result
// ----------------------------------------------------------------------------
// drives pixel transactions in phases that differ by register settings, with
// random gaps on the req side and random stalls on the rsp side. each
// accepted req transaction is turned into an expected pixel, and each rsp
// transaction is compared field by field with the oldest expected pixel.
// ----------------------------------------------------------------------------
module depth_pixel_converter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [23:0] pixel_value;
      logic [31:0] world_x;
      logic [31:0] world_y;
      logic        pixel_valid;
   } pixel_out_type;

   class pixel_scoreboard;
      logic [2:0]  mode_r;
      logic [15:0] scale_r;
      logic [23:0] disp_num_r;
      logic [23:0] ifx_r;
      logic [23:0] ify_r;
      logic [17:0] cx_r;
      logic [17:0] cy_r;
      logic [15:0] invalid_r;
      pixel_out_type pending[$];
      int          mismatches;
      int          checked;

      function void load_defaults();
         mode_r = dpc_pkg::MODE_RESET; scale_r = dpc_pkg::SCALE_RESET;
         disp_num_r = dpc_pkg::DISP_RESET;
         ifx_r = dpc_pkg::IFX_RESET; ify_r = dpc_pkg::IFY_RESET;
         cx_r = dpc_pkg::CX_RESET; cy_r = dpc_pkg::CY_RESET;
         invalid_r = dpc_pkg::INVALID_RESET;
      endfunction

      function void set_reg(dpc_pkg::csr_index_type idx, logic [23:0] v);
         case (idx)
            dpc_pkg::CSR_MODE:        mode_r = v[2:0];
            dpc_pkg::CSR_SCALE:       scale_r = v[15:0];
            dpc_pkg::CSR_DISP_NUM:    disp_num_r = v;
            dpc_pkg::CSR_INV_FOCAL_X: ifx_r = v;
            dpc_pkg::CSR_INV_FOCAL_Y: ify_r = v;
            dpc_pkg::CSR_CENTER_X:    cx_r = v[17:0];
            dpc_pkg::CSR_CENTER_Y:    cy_r = v[17:0];
            dpc_pkg::CSR_INVALID:     invalid_r = v[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] project(longint coord, longint center, longint inv,
                                    longint depth);
         longint diff;
         longint unsigned mag;
         longint unsigned r;
         diff = coord * 256 - center;
         mag = (diff < 0) ? -diff : diff;
         r = (mag * depth * inv + (64'd1 << 23)) >> 24;
         if (diff < 0) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            return 32'd0 - r[31:0];
         end
         if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
         return r[31:0];
      endfunction

      function void note_pixel(logic [15:0] depth, logic [9:0] col, logic [8:0] row);
         pixel_out_type e;
         longint unsigned pv;
         longint unsigned c;
         longint unsigned rw;
         bit ok;
         ok = depth != invalid_r;
         c = (col > 639) ? 639 : 64'(col);
         rw = (row > 479) ? 479 : 64'(row);
         pv = 0;
         e.world_x = 0;
         e.world_y = 0;
         case (mode_r)
            dpc_pkg::MODE_NORMALIZED: begin
               pv = (64'(depth) * scale_r + 64'h8000) >> 16;
               if (pv > 255) pv = 255;
            end
            dpc_pkg::MODE_DISP_8BIT: begin
               if (!ok) pv = 64'(invalid_r);
               else if (depth == 0) pv = 255;
               else pv = (64'(disp_num_r) + depth / 2) / depth;
               if (pv > 255) pv = 255;
            end
            dpc_pkg::MODE_DISP_FIXED: begin
               if (!ok) pv = 64'(invalid_r) * 256;
               else if (depth == 0) pv = 64'hFF_FFFF;
               else pv = (64'(disp_num_r) * 256 + depth / 2) / depth;
               if (pv > 64'hFF_FFFF) pv = 64'hFF_FFFF;
            end
            dpc_pkg::MODE_POINTCLOUD: begin
               if (ok) begin
                  pv = 64'(depth) * 256;
                  e.world_x = project(c, cx_r, ifx_r, depth);
                  e.world_y = project(rw, cy_r, ify_r, depth);
               end
            end
            dpc_pkg::MODE_VALID_MAP: pv = ok ? 255 : 0;
            default: pv = 64'(depth);
         endcase
         e.pixel_value = pv[23:0];
         e.pixel_valid = ok;
         pending.push_back(e);
      endfunction

      task check_pixel(pixel_out_type got);
         pixel_out_type e;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch("unexpected rsp transaction", 32'd0, 32'd0);
            return;
         end
         e = pending.pop_front();
         if (got.pixel_value !== e.pixel_value)
            report_mismatch("pixel_value", 32'(got.pixel_value), 32'(e.pixel_value));
         if (got.world_x !== e.world_x)
            report_mismatch("world_x", got.world_x, e.world_x);
         if (got.world_y !== e.world_y)
            report_mismatch("world_y", got.world_y, e.world_y);
         if (got.pixel_valid !== e.pixel_valid)
            report_mismatch("pixel_valid", 32'(got.pixel_valid), 32'(e.pixel_valid));
      endtask

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("mismatch %s at rsp %0d: got %h want %h", what, checked, got, want);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_depth = 0;
   logic [9:0] req_column = 0;
   logic [8:0] req_row = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [23:0] rsp_pixel_value;
   logic signed [31:0] rsp_world_x;
   logic signed [31:0] rsp_world_y;
   logic rsp_pixel_valid;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [23:0] csr_data = 0;

   pixel_scoreboard sb = new();
   int cycles = 0;
   int pixels_sent = 0;
   int phases = 0;

   depth_pixel_converter_top dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      pixel_out_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pixel_value = rsp_pixel_value;
         got.world_x = rsp_world_x;
         got.world_y = rsp_world_y;
         got.pixel_valid = rsp_pixel_valid;
         sb.check_pixel(got);
      end
   end

   // rsp side stall pattern
   initial begin
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
         if ($urandom_range(0, 9) < 3) w = 0;
         if (w != 0) begin
            rsp_stall <= 1;
            repeat (w) @(negedge clock);
         end
         rsp_stall <= 0;
         @(negedge clock);
      end
   end

   task automatic write_reg(dpc_pkg::csr_index_type idx, logic [23:0] v);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(negedge clock);
      csr_write <= 0;
      sb.set_reg(idx, v);
   endtask

   task automatic send_pixel(logic [15:0] d, logic [9:0] c, logic [8:0] r, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_depth <= d;
      req_column <= c;
      req_row <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(d, c, r);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_pixels(int n, logic [15:0] inv);
      int g;
      logic [15:0] d;
      for (int i = 0; i < n; i++) begin
         g = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
         case ($urandom_range(0, 7))
            0: d = inv;
            1: d = 0;
            2: d = 16'hFFFF;
            3: d = 16'($urandom_range(1, 32));
            default: d = 16'($urandom);
         endcase
         send_pixel(d, 10'($urandom), 9'($urandom), g);
      end
   endtask

   task automatic random_settings(logic [2:0] m);
      write_reg(dpc_pkg::CSR_MODE, 24'(m));
      write_reg(dpc_pkg::CSR_SCALE, 24'($urandom));
      write_reg(dpc_pkg::CSR_DISP_NUM,
                24'(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 70000)));
      write_reg(dpc_pkg::CSR_INV_FOCAL_X,
                ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom));
      write_reg(dpc_pkg::CSR_INV_FOCAL_Y,
                ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom));
      write_reg(dpc_pkg::CSR_CENTER_X, 24'($urandom));
      write_reg(dpc_pkg::CSR_CENTER_Y, 24'($urandom));
      write_reg(dpc_pkg::CSR_INVALID, ($urandom_range(0, 1)) ? 24'd0 : 24'(16'($urandom)));
   endtask

   initial begin
      sb.load_defaults();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset defaults in raw mode, then each mode at the extremes
      send_pixel(16'd0, 10'd0, 9'd0, 0);
      send_pixel(16'hFFFF, 10'h3FF, 9'h1FF, 0);
      drain();
      for (int m = 0; m < 8; m++) begin
         write_reg(dpc_pkg::CSR_MODE, 24'(m[2:0]));
         send_pixel(16'd0, 10'd0, 9'd0, 0);
         send_pixel(16'd1, 10'd639, 9'd479, 0);
         send_pixel(16'hFFFF, 10'h3FF, 9'h1FF, 1);
         drain();
      end
      // extreme registers, point cloud saturation and invalid code
      write_reg(dpc_pkg::CSR_MODE, 24'(dpc_pkg::MODE_POINTCLOUD));
      write_reg(dpc_pkg::CSR_SCALE, 24'hFFFF);
      write_reg(dpc_pkg::CSR_DISP_NUM, 24'hFFFFFF);
      write_reg(dpc_pkg::CSR_INV_FOCAL_X, 24'hFFFFFF);
      write_reg(dpc_pkg::CSR_INV_FOCAL_Y, 24'hFFFFFF);
      write_reg(dpc_pkg::CSR_CENTER_X, 24'h3FFFF);
      write_reg(dpc_pkg::CSR_CENTER_Y, 24'd0);
      write_reg(dpc_pkg::CSR_INVALID, 24'd1234);
      send_pixel(16'hFFFF, 10'd0, 9'h1FF, 0);
      send_pixel(16'd1234, 10'd5, 9'd5, 0);
      send_pixel(16'd0, 10'd5, 9'd5, 0);
      drain();
      for (int m = 0; m < 3; m++) begin
         write_reg(dpc_pkg::CSR_MODE, 24'(m[2:0]));
         send_pixel(16'd1234, 10'd1, 9'd1, 0);
         send_pixel(16'd0, 10'd1, 9'd1, 0);
         send_pixel(16'hFFFF, 10'd1, 9'd1, 0);
         send_pixel(16'd2, 10'd1, 9'd1, 0);
         drain();
      end

      // random phases, point cloud weighted
      for (int p = 0; p < 26; p++) begin
         random_settings((p % 3 == 0) ? 3'(dpc_pkg::MODE_POINTCLOUD)
                                      : 3'($urandom_range(0, 7)));
         random_pixels(48, sb.invalid_r);
         drain();
         phases++;
      end
      $display("sent %0d pixels over %0d random register phases plus directed cases",
               pixels_sent, phases);
      $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
